### rtl/mcm_pkg.sv
package mcm_pkg;

    localparam int LIMB_W     = 64;
    localparam int OP_W       = 576;
    localparam int PROD_W     = 1152;
    localparam int DIG_W      = 32;
    localparam int NUM_DIG    = 18;
    localparam int NUM_ROWS   = 36;
    localparam int FOLD_SHIFT = 240;
    localparam int LOW_W      = 336;
    localparam int TOP_W      = 240;
    localparam int ACC_W      = 579;
    localparam int CNT_W      = 3;

    // Fixed multiplier, most significant limb first.
    localparam logic [OP_W-1:0] MULT_CONST = {
        64'hb48c187cf5b22097, 64'h492edfcc0cc8e753, 64'hff74e54107684ed2,
        64'h256c3d3c662ea36c, 64'h20b2ca60cb78c509, 64'h6d8a15a13bee7cb0,
        64'he64dcb31c48228ec, 64'h4cec2c78af55c101, 64'hed7faa90747aaad9
    };

    typedef logic [PROD_W-1:0] wide_t;
    typedef logic [OP_W-1:0]   opnd_t;

    function automatic wide_t csa_sum(wide_t a, wide_t b, wide_t c);
        return a ^ b ^ c;
    endfunction

    function automatic wide_t csa_carry(wide_t a, wide_t b, wide_t c);
        return ((a & b) | (a & c) | (b & c)) << 1;
    endfunction

endpackage

### rtl/mcm_mult.sv
module mcm_mult (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  mcm_pkg::opnd_t operand,
    output logic          out_valid,
    output mcm_pkg::wide_t product
);

    logic [2*mcm_pkg::DIG_W-1:0] pp_reg  [mcm_pkg::NUM_DIG][mcm_pkg::NUM_DIG];
    logic [2*mcm_pkg::DIG_W-1:0] pp_next [mcm_pkg::NUM_DIG][mcm_pkg::NUM_DIG];

    mcm_pkg::wide_t row [mcm_pkg::NUM_ROWS];
    mcm_pkg::wide_t r24 [24];
    mcm_pkg::wide_t l2_next [16];
    mcm_pkg::wide_t l2_reg  [16];
    mcm_pkg::wide_t r11 [11];
    mcm_pkg::wide_t l4_next [8];
    mcm_pkg::wide_t l4_reg  [8];
    mcm_pkg::wide_t r6  [6];
    mcm_pkg::wide_t l6_next [4];
    mcm_pkg::wide_t l6_reg  [4];
    mcm_pkg::wide_t r3  [3];
    mcm_pkg::wide_t l8_next [2];
    mcm_pkg::wide_t l8_reg  [2];
    mcm_pkg::wide_t prod_next;
    mcm_pkg::wide_t prod_reg;

    logic [5:0] vld_reg;
    logic [5:0] vld_next;

    // Digit products, one 32x32 multiplier each.
    always_comb
    begin
        for (int i = 0; i < mcm_pkg::NUM_DIG; i++)
        begin
            for (int j = 0; j < mcm_pkg::NUM_DIG; j++)
            begin
                pp_next[i][j] = (2*mcm_pkg::DIG_W)'(operand[mcm_pkg::DIG_W*i +: mcm_pkg::DIG_W])
                    * (2*mcm_pkg::DIG_W)'(mcm_pkg::MULT_CONST[mcm_pkg::DIG_W*j +: mcm_pkg::DIG_W]);
            end
        end
    end

    // Products with the same row digit and parity never overlap: pack them.
    always_comb
    begin
        for (int r = 0; r < mcm_pkg::NUM_ROWS; r++)
        begin
            row[r] = '0;
        end
        for (int i = 0; i < mcm_pkg::NUM_DIG; i++)
        begin
            for (int j = 0; j < mcm_pkg::NUM_DIG; j++)
            begin
                row[2*i + (j % 2)] = row[2*i + (j % 2)]
                    | (mcm_pkg::wide_t'(pp_reg[i][j]) << (mcm_pkg::DIG_W*(i+j)));
            end
        end
    end

    // Carry-save tree, two compressor layers per stage.
    always_comb
    begin
        for (int g = 0; g < 12; g++)
        begin
            r24[2*g]   = mcm_pkg::csa_sum(row[3*g], row[3*g+1], row[3*g+2]);
            r24[2*g+1] = mcm_pkg::csa_carry(row[3*g], row[3*g+1], row[3*g+2]);
        end
        for (int g = 0; g < 8; g++)
        begin
            l2_next[2*g]   = mcm_pkg::csa_sum(r24[3*g], r24[3*g+1], r24[3*g+2]);
            l2_next[2*g+1] = mcm_pkg::csa_carry(r24[3*g], r24[3*g+1], r24[3*g+2]);
        end
    end

    always_comb
    begin
        for (int g = 0; g < 5; g++)
        begin
            r11[2*g]   = mcm_pkg::csa_sum(l2_reg[3*g], l2_reg[3*g+1], l2_reg[3*g+2]);
            r11[2*g+1] = mcm_pkg::csa_carry(l2_reg[3*g], l2_reg[3*g+1], l2_reg[3*g+2]);
        end
        r11[10] = l2_reg[15];
        for (int g = 0; g < 3; g++)
        begin
            l4_next[2*g]   = mcm_pkg::csa_sum(r11[3*g], r11[3*g+1], r11[3*g+2]);
            l4_next[2*g+1] = mcm_pkg::csa_carry(r11[3*g], r11[3*g+1], r11[3*g+2]);
        end
        l4_next[6] = r11[9];
        l4_next[7] = r11[10];
    end

    always_comb
    begin
        for (int g = 0; g < 2; g++)
        begin
            r6[2*g]   = mcm_pkg::csa_sum(l4_reg[3*g], l4_reg[3*g+1], l4_reg[3*g+2]);
            r6[2*g+1] = mcm_pkg::csa_carry(l4_reg[3*g], l4_reg[3*g+1], l4_reg[3*g+2]);
        end
        r6[4] = l4_reg[6];
        r6[5] = l4_reg[7];
        for (int g = 0; g < 2; g++)
        begin
            l6_next[2*g]   = mcm_pkg::csa_sum(r6[3*g], r6[3*g+1], r6[3*g+2]);
            l6_next[2*g+1] = mcm_pkg::csa_carry(r6[3*g], r6[3*g+1], r6[3*g+2]);
        end
    end

    always_comb
    begin
        r3[0] = mcm_pkg::csa_sum(l6_reg[0], l6_reg[1], l6_reg[2]);
        r3[1] = mcm_pkg::csa_carry(l6_reg[0], l6_reg[1], l6_reg[2]);
        r3[2] = l6_reg[3];
        l8_next[0] = mcm_pkg::csa_sum(r3[0], r3[1], r3[2]);
        l8_next[1] = mcm_pkg::csa_carry(r3[0], r3[1], r3[2]);
    end

    assign prod_next = l8_reg[0] + l8_reg[1];
    assign vld_next  = {vld_reg[4:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg   <= pp_next;
        l2_reg   <= l2_next;
        l4_reg   <= l4_next;
        l6_reg   <= l6_next;
        l8_reg   <= l8_next;
        prod_reg <= prod_next;
    end

    assign out_valid = vld_reg[5];
    assign product   = prod_reg;

endmodule

### rtl/mul_const_mod_pseudo_mersenne_576.sv
// An accepted request passes the input register, the multiplier pipeline and the fold
// stages before done rises with its result; one request may be accepted in every cycle.
// The depth is set by the 324 digit multipliers, the four-stage carry-save tree,
// the 1152-bit final add and four fold stages. busy is always low.
// Reset (rst_n low, asynchronous) drops every request in flight; done stays low.
// The receiver cannot stall: done lasts one cycle and results are never held.
module mul_const_mod_pseudo_mersenne_576 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] operand_limb_0,
    input  logic [63:0] operand_limb_1,
    input  logic [63:0] operand_limb_2,
    input  logic [63:0] operand_limb_3,
    input  logic [63:0] operand_limb_4,
    input  logic [63:0] operand_limb_5,
    input  logic [63:0] operand_limb_6,
    input  logic [63:0] operand_limb_7,
    input  logic [63:0] operand_limb_8,
    output logic        done,
    output logic [63:0] result_limb_0,
    output logic [63:0] result_limb_1,
    output logic [63:0] result_limb_2,
    output logic [63:0] result_limb_3,
    output logic [63:0] result_limb_4,
    output logic [63:0] result_limb_5,
    output logic [63:0] result_limb_6,
    output logic [63:0] result_limb_7,
    output logic [63:0] result_limb_8
);

    // Input capture.
    mcm_pkg::opnd_t op_reg;
    logic           in_vld_reg;

    // Product from the multiplier pipeline.
    logic           prod_vld;
    mcm_pkg::wide_t product;
    logic [mcm_pkg::OP_W-1:0]  lo;
    logic [mcm_pkg::OP_W-1:0]  hi;

    // Fold stage 1: d = lo - hi, s = l336 + h240 (full 337-bit sum).
    logic signed [mcm_pkg::ACC_W-1:0] d_next, d_reg;
    logic [mcm_pkg::LOW_W:0]          s_next, s1_reg;
    logic [mcm_pkg::TOP_W-1:0]        top1_reg;
    logic                             r1_vld_reg;

    // Fold stage 2: e = d - h240.
    logic signed [mcm_pkg::ACC_W-1:0] e_next, e_reg;
    logic [mcm_pkg::LOW_W:0]          s2_reg;
    logic                             r2_vld_reg;

    // Fold stage 3: v = e + s*2^240; v = cnt*2^576 + x.
    logic signed [mcm_pkg::ACC_W-1:0] v_next, v_reg;
    logic                             r3_vld_reg;

    // Final correction: add cnt*(2^240 - 1) modulo 2^576.
    logic signed [mcm_pkg::CNT_W-1:0] cnt;
    logic [mcm_pkg::OP_W-1:0]         cnt_ext;
    logic [mcm_pkg::OP_W-1:0]         res_next, res_reg;
    logic                             done_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            r1_vld_reg <= 1'b0;
            r2_vld_reg <= 1'b0;
            r3_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start & ~busy;
            r1_vld_reg <= prod_vld;
            r2_vld_reg <= r1_vld_reg;
            r3_vld_reg <= r2_vld_reg;
            done_reg   <= r3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= {operand_limb_8, operand_limb_7, operand_limb_6, operand_limb_5,
                     operand_limb_4, operand_limb_3, operand_limb_2, operand_limb_1,
                     operand_limb_0};
        d_reg    <= d_next;
        s1_reg   <= s_next;
        top1_reg <= hi[mcm_pkg::OP_W-1 -: mcm_pkg::TOP_W];
        e_reg    <= e_next;
        s2_reg   <= s1_reg;
        v_reg    <= v_next;
        res_reg  <= res_next;
    end

    mcm_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_vld_reg),
        .operand   (op_reg),
        .out_valid (prod_vld),
        .product   (product)
    );

    assign lo = product[mcm_pkg::OP_W-1:0];
    assign hi = product[mcm_pkg::PROD_W-1:mcm_pkg::OP_W];

    // Split the high half into its lower 336 and upper 240 bits.
    assign d_next = $signed({3'b000, lo}) - $signed({3'b000, hi});
    assign s_next = {1'b0, hi[mcm_pkg::LOW_W-1:0]}
                  + (mcm_pkg::LOW_W+1)'(hi[mcm_pkg::OP_W-1 -: mcm_pkg::TOP_W]);

    assign e_next = d_reg - $signed({(mcm_pkg::ACC_W-mcm_pkg::TOP_W)'(0), top1_reg});

    // Shifted sum: 337 + 240 = 577 bits, zero extended to the accumulator.
    assign v_next = e_reg + $signed({2'b00, s2_reg, {mcm_pkg::FOLD_SHIFT{1'b0}}});

    // Overflow count lies in -2..2; remove it as cnt*m.
    assign cnt      = v_reg[mcm_pkg::ACC_W-1:mcm_pkg::OP_W];
    assign cnt_ext  = mcm_pkg::OP_W'(cnt);
    assign res_next = v_reg[mcm_pkg::OP_W-1:0] + (cnt_ext << mcm_pkg::FOLD_SHIFT) - cnt_ext;

    assign done          = done_reg;
    assign result_limb_0 = res_reg[0*mcm_pkg::LIMB_W +: mcm_pkg::LIMB_W];
    assign result_limb_1 = res_reg[1*mcm_pkg::LIMB_W +: mcm_pkg::LIMB_W];
    assign result_limb_2 = res_reg[2*mcm_pkg::LIMB_W +: mcm_pkg::LIMB_W];
    assign result_limb_3 = res_reg[3*mcm_pkg::LIMB_W +: mcm_pkg::LIMB_W];
    assign result_limb_4 = res_reg[4*mcm_pkg::LIMB_W +: mcm_pkg::LIMB_W];
    assign result_limb_5 = res_reg[5*mcm_pkg::LIMB_W +: mcm_pkg::LIMB_W];
    assign result_limb_6 = res_reg[6*mcm_pkg::LIMB_W +: mcm_pkg::LIMB_W];
    assign result_limb_7 = res_reg[7*mcm_pkg::LIMB_W +: mcm_pkg::LIMB_W];
    assign result_limb_8 = res_reg[8*mcm_pkg::LIMB_W +: mcm_pkg::LIMB_W];

    // A result only ever follows an accepted request by the full latency.
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 11))
        else $error("result strobe without a matching request");

    // lo - hi always lies strictly between -2^576 and 2^576.
    a_diff_range: assert property (@(posedge clk) disable iff (!rst_n)
        r1_vld_reg |-> (d_reg[mcm_pkg::ACC_W-1] == d_reg[mcm_pkg::OP_W]))
        else $error("fold difference out of range");

    // The overflow count stays within -2..2.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        r3_vld_reg |-> (cnt != 3'sb011 && cnt != 3'sb100 && cnt != 3'sb101))
        else $error("fold overflow count out of range");

endmodule

### dv/tb.sv
module tb;

    localparam int LATENCY = 11;
    localparam int N_RANDOM = 1400;

    // Modulus m = 2^576 - 2^240 + 1.
    localparam logic [mcm_pkg::OP_W:0] MODULUS = (1'b1 << mcm_pkg::OP_W)
        - (1'b1 << mcm_pkg::FOLD_SHIFT) + 1'b1;

    // Compute the reduced product of one request; mirrors the fold with signed count.
    function automatic mcm_pkg::opnd_t mulmod_result(mcm_pkg::opnd_t x);
        logic [mcm_pkg::PROD_W-1:0] prod;
        logic [mcm_pkg::OP_W-1:0]   lo;
        logic [mcm_pkg::OP_W-1:0]   hi;
        logic [mcm_pkg::OP_W-1:0]   top;
        logic [mcm_pkg::OP_W-1:0]   shifted;
        logic [mcm_pkg::OP_W+3:0]   acc;
        logic [mcm_pkg::OP_W:0]     sum;
        int                         cnt;
        prod = mcm_pkg::PROD_W'(x) * mcm_pkg::PROD_W'(mcm_pkg::MULT_CONST);
        lo  = prod[mcm_pkg::OP_W-1:0];
        hi  = prod[mcm_pkg::PROD_W-1:mcm_pkg::OP_W];
        top = mcm_pkg::OP_W'(hi[mcm_pkg::OP_W-1:mcm_pkg::LOW_W]);
        sum = (mcm_pkg::OP_W+1)'(hi[mcm_pkg::LOW_W-1:0]) + (mcm_pkg::OP_W+1)'(top);
        cnt = int'(sum[mcm_pkg::LOW_W]);
        shifted = mcm_pkg::OP_W'(sum[mcm_pkg::LOW_W-1:0]) << mcm_pkg::FOLD_SHIFT;
        acc = {4'b0, lo};
        acc = acc - {4'b0, hi};
        if (acc[mcm_pkg::OP_W]) cnt = cnt - 1;
        acc = {4'b0, acc[mcm_pkg::OP_W-1:0]} - {4'b0, top};
        if (acc[mcm_pkg::OP_W]) cnt = cnt - 1;
        acc = {4'b0, acc[mcm_pkg::OP_W-1:0]} + {4'b0, shifted};
        if (acc[mcm_pkg::OP_W]) cnt = cnt + 1;
        // Add cnt*(2^240 - 1) modulo 2^576.
        lo = acc[mcm_pkg::OP_W-1:0];
        if (cnt > 0)
            lo = lo + (mcm_pkg::OP_W'(cnt) << mcm_pkg::FOLD_SHIFT) - mcm_pkg::OP_W'(cnt);
        else if (cnt < 0)
            lo = lo - (mcm_pkg::OP_W'(-cnt) << mcm_pkg::FOLD_SHIFT) + mcm_pkg::OP_W'(-cnt);
        return lo;
    endfunction

    class product_board;
        mcm_pkg::opnd_t pending_q[$];
        int             errors;

        function void note_request(mcm_pkg::opnd_t x);
            pending_q.push_back(mulmod_result(x));
        endfunction

        function void check_result(mcm_pkg::opnd_t got);
            mcm_pkg::opnd_t want;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            for (int k = 0; k < 9; k++)
                if (want[64*k +: 64] !== got[64*k +: 64])
                begin
                    $display("%0t: limb %0d expected %h actual %h", $time, k,
                             want[64*k +: 64], got[64*k +: 64]);
                    errors++;
                end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic [63:0] op [9];
    logic [63:0] res [9];

    product_board board;

    mul_const_mod_pseudo_mersenne_576 u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operand_limb_0(op[0]), .operand_limb_1(op[1]), .operand_limb_2(op[2]),
        .operand_limb_3(op[3]), .operand_limb_4(op[4]), .operand_limb_5(op[5]),
        .operand_limb_6(op[6]), .operand_limb_7(op[7]), .operand_limb_8(op[8]),
        .done(done),
        .result_limb_0(res[0]), .result_limb_1(res[1]), .result_limb_2(res[2]),
        .result_limb_3(res[3]), .result_limb_4(res[4]), .result_limb_5(res[5]),
        .result_limb_6(res[6]), .result_limb_7(res[7]), .result_limb_8(res[8])
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample results at each edge; the receiver never stalls.
    always @(posedge clk)
    begin
        mcm_pkg::opnd_t got;
        if (rst_n && done)
        begin
            for (int k = 0; k < 9; k++)
                got[64*k +: 64] = res[k];
            board.check_result(got);
        end
    end

    // Present one request; hold start until accepted, optionally idling first.
    task automatic send_request(mcm_pkg::opnd_t x, bit allow_idle);
        while (allow_idle && $urandom_range(99) < 28)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        for (int k = 0; k < 9; k++)
            op[k] <= x[64*k +: 64];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(x);
    endtask

    function automatic mcm_pkg::opnd_t random_operand();
        mcm_pkg::opnd_t x;
        for (int k = 0; k < 9; k++)
        begin
            x[64*k +: 64] = {$urandom, $urandom};
            // Bias some limbs to all-zero or all-one to stress carries.
            case ($urandom_range(7))
                0: x[64*k +: 64] = '0;
                1: x[64*k +: 64] = '1;
                default: ;
            endcase
        end
        return x;
    endfunction

    // Drain: stop sending until every expected result has arrived.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        mcm_pkg::opnd_t x;
        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        for (int k = 0; k < 9; k++)
            op[k] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, m and its neighbors, single bits, the constant.
        send_request('0, 1'b0);
        send_request(mcm_pkg::opnd_t'(1), 1'b0);
        send_request('1, 1'b0);
        send_request(MODULUS[mcm_pkg::OP_W-1:0], 1'b0);
        send_request(MODULUS[mcm_pkg::OP_W-1:0] - 1, 1'b0);
        send_request(MODULUS[mcm_pkg::OP_W-1:0] + 1, 1'b0);
        send_request(mcm_pkg::opnd_t'(1) << (mcm_pkg::OP_W-1), 1'b0);
        send_request(mcm_pkg::opnd_t'(1) << mcm_pkg::FOLD_SHIFT, 1'b0);
        send_request((mcm_pkg::opnd_t'(1) << mcm_pkg::FOLD_SHIFT) - 1, 1'b0);
        send_request(~((mcm_pkg::opnd_t'(1) << mcm_pkg::FOLD_SHIFT) - 1), 1'b0);
        send_request(mcm_pkg::MULT_CONST, 1'b0);
        send_request(~mcm_pkg::MULT_CONST, 1'b0);
        for (int k = 0; k < 9; k++)
            send_request(mcm_pkg::opnd_t'(64'hFFFF_FFFF_FFFF_FFFF) << (64*k), 1'b0);
        drain();

        // Random part: first a back-to-back stretch, then random idling.
        for (int i = 0; i < N_RANDOM; i++)
        begin
            x = random_operand();
            send_request(x, i >= 300);
            if (i == 700)
                drain();
        end
        drain();
        start <= 1'b0;
        repeat (LATENCY + 5) @(posedge clk);

        if (board.errors == 0 && board.pending_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hold a hard limit on run length.
    initial
    begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
